// ----- src/dwm_pkg.sv -----
// Package for the decimal word machine: sizes, status and mode codes,
// opcode characters and the memory request struct.
// No dependencies.
package dwm_pkg;

    localparam int MEM_WORDS   = 100;
    localparam int BLOCK_WORDS = 10;

    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 3;
    localparam int BLK_W  = 4;
    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int IC_W   = $clog2(MEM_WORDS + 1);

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_NEED  = 3'd1;
    localparam status_t ST_PRINT = 3'd2;
    localparam status_t ST_HALT  = 3'd3;
    localparam status_t ST_END   = 3'd4;
    localparam status_t ST_BAD   = 3'd5;
    localparam status_t ST_FULL  = 3'd6;

    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_NEW   = 3'd0;
    localparam mode_t MODE_LOAD  = 3'd1;
    localparam mode_t MODE_START = 3'd2;
    localparam mode_t MODE_STEP  = 3'd3;
    localparam mode_t MODE_DATA  = 3'd4;

    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

endpackage

// ----- src/dwm_cmd_if.sv -----
// Input channel of the decimal word machine: valid/ready plus mode and word.
// Depends on dwm_pkg.
interface dwm_cmd_if
    import dwm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] word;

    modport source (output valid, mode, word, input ready);
    modport sink   (input valid, mode, word, output ready);
endinterface

// ----- src/dwm_res_if.sv -----
// Result channel of the decimal word machine: valid/ready plus result fields.
// Depends on dwm_pkg.
interface dwm_res_if
    import dwm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] out_word;
    logic [BLK_W-1:0]  block;
    logic              last;

    modport source (output valid, status, out_word, block, last, input ready);
    modport sink   (input valid, status, out_word, block, last, output ready);
endinterface

// ----- src/decimal_word_machine_core.sv -----
// Decimal word machine core: control sequencer around the word store.
// Depends on dwm_pkg, dwm_cmd_if, dwm_res_if and dwm_store.
//
// Usage:
//   cmd carries one item per transfer (mode, word); res returns result items
//   (status, out_word, block, last), last marking the final one of an item.
//   Every item gives one result, except a PD step which gives ten.
//   One item is worked on at a time. New job, load, start and data items
//   pass through S_EMIT to the result register; an execute step goes through
//   fetch read, decode and result, LR and CR add an operand read, and a
//   step answered without a fetch (waiting for data, counter past the end)
//   goes straight to the result. A PD step streams its ten words at one
//   per cycle from the store's single read port when the receiver keeps up.
//   A new item is taken while the previous result still waits in the output
//   register; a stall on res holds that register and stops the sequencer
//   before it produces the next result, with nothing lost.
//   New job clears the whole store through per-word valid bits.
//   After reset the store reads all zero, R is zero, the counter is zero
//   and the toggle is set; no clearing pass is needed.
module decimal_word_machine_core
    import dwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dwm_cmd_if.sink     cmd,
    dwm_res_if.source   res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_OPER  = 5'b00100,
        S_PRINT = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [IC_W-1:0]   ic_reg, ic_next;
    logic [WORD_W-1:0] gr_reg, gr_next;
    logic              tog_reg, tog_next;
    logic              wait_reg, wait_next;
    logic [BLK_W-1:0]  dblk_reg, dblk_next;
    logic [BLK_W-1:0]  doff_reg, doff_next;
    logic              load_op_reg, load_op_next;
    logic [BLK_W-1:0]  prt_blk_reg, prt_blk_next;
    logic [BLK_W-1:0]  prt_cnt_reg, prt_cnt_next;
    status_t           rst_reg, rst_next;
    logic [BLK_W-1:0]  rblk_reg, rblk_next;

    logic              ov_reg, ov_next;
    status_t           ost_reg, ost_next;
    logic [WORD_W-1:0] ow_reg, ow_next;
    logic [BLK_W-1:0]  ob_reg, ob_next;
    logic              ol_reg, ol_next;

    mem_req_t          mreq;
    logic [WORD_W-1:0] rdata;
    logic              out_free;

    // decode of the fetched word
    logic [7:0]        op0, op1, d2, d3;
    logic              digits;
    logic [BLK_W-1:0]  op_blk;
    logic [7:0]        op_addr;
    logic [7:0]        op_end;

    function automatic logic [ADDR_W-1:0] block_base(input logic [BLK_W-1:0] b);
        return ADDR_W'(b * BLOCK_WORDS);
    endfunction

    dwm_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (rdata)
    );

    assign out_free  = !ov_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign res.valid    = ov_reg;
    assign res.status   = ost_reg;
    assign res.out_word = ow_reg;
    assign res.block    = ob_reg;
    assign res.last     = ol_reg;

    assign op0     = rdata[31:24];
    assign op1     = rdata[23:16];
    assign d2      = rdata[15:8];
    assign d3      = rdata[7:0];
    assign digits  = (d2 >= CH_0) && (d2 <= CH_9) && (d3 >= CH_0) && (d3 <= CH_9);
    assign op_blk  = d2[3:0];
    assign op_addr = 8'(op_blk) * 8'(BLOCK_WORDS) + 8'(d3[3:0]);
    assign op_end  = 8'(op_blk) * 8'(BLOCK_WORDS) + 8'(BLOCK_WORDS);

    always_comb
    begin
        state_next   = state_reg;
        ic_next      = ic_reg;
        gr_next      = gr_reg;
        tog_next     = tog_reg;
        wait_next    = wait_reg;
        dblk_next    = dblk_reg;
        doff_next    = doff_reg;
        load_op_next = load_op_reg;
        prt_blk_next = prt_blk_reg;
        prt_cnt_next = prt_cnt_reg;
        rst_next     = rst_reg;
        rblk_next    = rblk_reg;

        ov_next  = ov_reg && !res.ready;
        ost_next = ost_reg;
        ow_next  = ow_reg;
        ob_next  = ob_reg;
        ol_next  = ol_reg;

        mreq = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    rst_next   = ST_OK;
                    rblk_next  = '0;
                    state_next = S_EMIT;
                    case (cmd.mode)
                        MODE_NEW:
                        begin
                            mreq.clr  = 1'b1;
                            ic_next   = '0;
                            gr_next   = '0;
                            tog_next  = 1'b1;
                            wait_next = 1'b0;
                            dblk_next = '0;
                            doff_next = '0;
                        end
                        MODE_LOAD:
                        begin
                            if (ic_reg >= IC_W'(MEM_WORDS))
                            begin
                                rst_next = ST_FULL;
                            end
                            else
                            begin
                                mreq.wr_en = 1'b1;
                                mreq.addr  = ic_reg[ADDR_W-1:0];
                                mreq.wdata = cmd.word;
                                ic_next    = IC_W'(ic_reg + 1'b1);
                            end
                        end
                        MODE_START:
                        begin
                            ic_next   = '0;
                            wait_next = 1'b0;
                        end
                        MODE_STEP:
                        begin
                            if (wait_reg)
                            begin
                                rst_next  = ST_NEED;
                                rblk_next = dblk_reg;
                            end
                            else if (ic_reg >= IC_W'(MEM_WORDS))
                            begin
                                rst_next = ST_END;
                            end
                            else
                            begin
                                mreq.rd_en = 1'b1;
                                mreq.addr  = ic_reg[ADDR_W-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        MODE_DATA:
                        begin
                            if (wait_reg)
                            begin
                                rblk_next = dblk_reg;
                                if (cmd.word[31:24] == 8'd0)
                                begin
                                    // empty word ends the card
                                    wait_next = 1'b0;
                                end
                                else
                                begin
                                    mreq.wr_en = 1'b1;
                                    mreq.addr  = block_base(dblk_reg) + ADDR_W'(doff_reg);
                                    mreq.wdata = cmd.word;
                                    if (doff_reg == BLK_W'(BLOCK_WORDS - 1))
                                    begin
                                        wait_next = 1'b0;
                                        doff_next = '0;
                                    end
                                    else
                                    begin
                                        doff_next = BLK_W'(doff_reg + 1'b1);
                                        rst_next  = ST_NEED;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                state_next = S_EMIT;
                rst_next   = ST_OK;
                rblk_next  = '0;
                if (op0 == 8'd0)
                begin
                    rst_next = ST_END;
                end
                else if (op0 == CH_H)
                begin
                    // counter stays on the halt word
                    rst_next = ST_HALT;
                end
                else
                begin
                    ic_next = IC_W'(ic_reg + 1'b1);
                    if (op1 == CH_D && (op0 == CH_G || op0 == CH_P))
                    begin
                        if (!digits || op_end > 8'(MEM_WORDS))
                        begin
                            rst_next = ST_BAD;
                        end
                        else if (op0 == CH_G)
                        begin
                            wait_next = 1'b1;
                            dblk_next = op_blk;
                            doff_next = '0;
                            rst_next  = ST_NEED;
                            rblk_next = op_blk;
                        end
                        else
                        begin
                            mreq.rd_en   = 1'b1;
                            mreq.addr    = block_base(op_blk);
                            prt_blk_next = op_blk;
                            prt_cnt_next = '0;
                            state_next   = S_PRINT;
                        end
                    end
                    else if (op1 == CH_R && (op0 == CH_L || op0 == CH_S || op0 == CH_C))
                    begin
                        if (!digits || op_addr >= 8'(MEM_WORDS))
                        begin
                            rst_next = ST_BAD;
                        end
                        else if (op0 == CH_S)
                        begin
                            mreq.wr_en = 1'b1;
                            mreq.addr  = op_addr[ADDR_W-1:0];
                            mreq.wdata = gr_reg;
                        end
                        else
                        begin
                            mreq.rd_en   = 1'b1;
                            mreq.addr    = op_addr[ADDR_W-1:0];
                            load_op_next = (op0 == CH_L);
                            state_next   = S_OPER;
                        end
                    end
                    else if (op0 == CH_B && op1 == CH_T)
                    begin
                        if (!digits || op_addr >= 8'(MEM_WORDS))
                        begin
                            rst_next = ST_BAD;
                        end
                        else if (tog_reg)
                        begin
                            ic_next = IC_W'(op_addr);
                        end
                    end
                end
            end

            S_OPER:
            begin
                if (load_op_reg)
                begin
                    gr_next = rdata;
                end
                else
                begin
                    tog_next = (rdata == gr_reg);
                end
                state_next = S_EMIT;
            end

            S_PRINT:
            begin
                // read data holds while the result register is blocked
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    ost_next = ST_PRINT;
                    ow_next  = rdata;
                    ob_next  = prt_blk_reg;
                    ol_next  = (prt_cnt_reg == BLK_W'(BLOCK_WORDS - 1));
                    if (prt_cnt_reg == BLK_W'(BLOCK_WORDS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        prt_cnt_next = BLK_W'(prt_cnt_reg + 1'b1);
                        mreq.rd_en   = 1'b1;
                        mreq.addr    = block_base(prt_blk_reg)
                                     + ADDR_W'(prt_cnt_reg) + ADDR_W'(1);
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = rst_reg;
                    ow_next    = '0;
                    ob_next    = rblk_reg;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ic_reg    <= '0;
            gr_reg    <= '0;
            tog_reg   <= 1'b1;
            wait_reg  <= 1'b0;
            dblk_reg  <= '0;
            doff_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ic_reg    <= ic_next;
            gr_reg    <= gr_next;
            tog_reg   <= tog_next;
            wait_reg  <= wait_next;
            dblk_reg  <= dblk_next;
            doff_reg  <= doff_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_op_reg <= load_op_next;
        prt_blk_reg <= prt_blk_next;
        prt_cnt_reg <= prt_cnt_next;
        rst_reg     <= rst_next;
        rblk_reg    <= rblk_next;
        ost_reg     <= ost_next;
        ow_reg      <= ow_next;
        ob_reg      <= ob_next;
        ol_reg      <= ol_next;
    end

endmodule

// ----- src/dwm_store.sv -----
// Word memory of the machine: one port, registered read, per-word valid bits
// so that a new job clears the whole store by dropping them.
// Depends on dwm_pkg.
module dwm_store
    import dwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0]    mem_array [MEM_WORDS];
    logic [MEM_WORDS-1:0] vld_reg;
    logic [WORD_W-1:0]    rd_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.clr)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_reg     <= mem_array[req.addr];
            rd_vld_reg <= vld_reg[req.addr];
        end
    end

    // a word never written since the last new job reads as zero
    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for decimal_word_machine_core: card-job programs are driven on cmd,
// results on res are compared with a built-in predictor of the machine.
// Depends on dwm_pkg, dwm_cmd_if, dwm_res_if and the RTL under src.
`timescale 1ns / 100ps

module testbench
    import dwm_pkg::*;
();

    localparam int    CYCLE_LIMIT = 200000;
    localparam int    IDLE_PCT    = 23;
    localparam int    RANDOM_GOAL = 100;   // reached at the latest once the full-memory job is done
    localparam mode_t MODE_SPARE  = 3'd7;

    typedef struct {
        status_t            status;
        logic [WORD_W-1:0]  out_word;
        logic [BLK_W-1:0]   block;
        logic               last;
    } result_t;

    // Predicts the machine and holds the results still owed by the block.
    class job_scoreboard;
        logic [WORD_W-1:0] mem [MEM_WORDS];
        int                counter;
        logic [WORD_W-1:0] acc;
        bit                toggle;
        int                data_ptr;
        bit                awaiting;
        result_t           owed_q[$];
        int                failures;

        function new();
            failures = 0;
            clear_job();
        endfunction

        function void clear_job();
            for (int i = 0; i < MEM_WORDS; i++)
                mem[i] = '0;
            counter  = 0;
            acc      = '0;
            toggle   = 1'b1;
            data_ptr = 0;
            awaiting = 1'b0;
        endfunction

        function void owe(status_t st, logic [WORD_W-1:0] w, int blk, bit lst);
            result_t r;
            r.status   = st;
            r.out_word = w;
            r.block    = blk[BLK_W-1:0];
            r.last     = lst;
            owed_q.push_back(r);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function void exec_instr();
            logic [WORD_W-1:0] ir;
            logic [7:0]        op0;
            logic [7:0]        op1;
            logic [7:0]        d2;
            logic [7:0]        d3;
            bit                digits;
            int                blk;
            int                addr;
            int                base;
            int                i;
            if (awaiting) begin
                owe(ST_NEED, '0, data_ptr / BLOCK_WORDS, 1'b1);
                return;
            end
            if (counter >= MEM_WORDS || mem[counter][31:24] == 8'h00) begin
                owe(ST_END, '0, 0, 1'b1);
                return;
            end
            ir  = mem[counter];
            op0 = ir[31:24];
            op1 = ir[23:16];
            d2  = ir[15:8];
            d3  = ir[7:0];
            // halt leaves the counter on the H word
            if (op0 == CH_H) begin
                owe(ST_HALT, '0, 0, 1'b1);
                return;
            end
            counter++;
            digits = is_digit(d2) && is_digit(d3);
            blk    = digits ? int'(d2) - int'(CH_0) : 0;
            addr   = digits ? blk * 10 + int'(d3) - int'(CH_0) : 0;
            base   = blk * BLOCK_WORDS;
            if (op1 == CH_D && (op0 == CH_G || op0 == CH_P)) begin
                if (!digits || base + BLOCK_WORDS > MEM_WORDS) begin
                    owe(ST_BAD, '0, 0, 1'b1);
                end
                else if (op0 == CH_G) begin
                    awaiting = 1'b1;
                    data_ptr = base;
                    owe(ST_NEED, '0, blk, 1'b1);
                end
                else begin
                    for (i = 0; i < BLOCK_WORDS; i++)
                        owe(ST_PRINT, mem[base + i], blk, i == BLOCK_WORDS - 1);
                end
            end
            else if (op1 == CH_R && (op0 == CH_L || op0 == CH_S || op0 == CH_C)) begin
                if (!digits || addr >= MEM_WORDS) begin
                    owe(ST_BAD, '0, 0, 1'b1);
                end
                else begin
                    if (op0 == CH_L)
                        acc = mem[addr];
                    else if (op0 == CH_S)
                        mem[addr] = acc;
                    else
                        toggle = (mem[addr] == acc);
                    owe(ST_OK, '0, 0, 1'b1);
                end
            end
            else if (op0 == CH_B && op1 == CH_T) begin
                if (!digits || addr >= MEM_WORDS) begin
                    owe(ST_BAD, '0, 0, 1'b1);
                end
                else begin
                    if (toggle)
                        counter = addr;
                    owe(ST_OK, '0, 0, 1'b1);
                end
            end
            else begin
                owe(ST_OK, '0, 0, 1'b1);
            end
        endfunction

        // Called on every accepted cmd transfer; returns the first predicted status.
        function status_t note_command(mode_t m, logic [WORD_W-1:0] w);
            int first;
            int blk;
            first = owed_q.size();
            case (m)
                MODE_NEW:
                begin
                    clear_job();
                    owe(ST_OK, '0, 0, 1'b1);
                end
                MODE_LOAD:
                begin
                    if (counter >= MEM_WORDS) begin
                        owe(ST_FULL, '0, 0, 1'b1);
                    end
                    else begin
                        mem[counter] = w;
                        counter++;
                        owe(ST_OK, '0, 0, 1'b1);
                    end
                end
                MODE_START:
                begin
                    counter  = 0;
                    awaiting = 1'b0;
                    owe(ST_OK, '0, 0, 1'b1);
                end
                MODE_STEP:
                    exec_instr();
                MODE_DATA:
                begin
                    if (!awaiting || data_ptr >= MEM_WORDS) begin
                        owe(ST_OK, '0, 0, 1'b1);
                    end
                    else begin
                        blk = data_ptr / BLOCK_WORDS;
                        if (w[31:24] == 8'h00) begin
                            // empty word closes the card
                            awaiting = 1'b0;
                            owe(ST_OK, '0, blk, 1'b1);
                        end
                        else begin
                            mem[data_ptr] = w;
                            data_ptr++;
                            if (data_ptr % BLOCK_WORDS == 0)
                                awaiting = 1'b0;
                            owe(awaiting ? ST_NEED : ST_OK, '0, blk, 1'b1);
                        end
                    end
                end
                default:
                    owe(ST_OK, '0, 0, 1'b1);
            endcase
            return owed_q[first].status;
        endfunction

        function void check_result(status_t st, logic [WORD_W-1:0] w,
                                   logic [BLK_W-1:0] blk, logic lst);
            result_t e;
            if (owed_q.size() == 0) begin
                $error("unexpected result: status %0d word %h block %0d last %0b",
                       st, w, blk, lst);
                failures++;
                return;
            end
            e = owed_q.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                failures++;
            end
            if (w !== e.out_word) begin
                $error("out_word: expected %h, actual %h", e.out_word, w);
                failures++;
            end
            if (blk !== e.block) begin
                $error("block: expected %0d, actual %0d", e.block, blk);
                failures++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, lst);
                failures++;
            end
        endfunction

        function int owed();
            return owed_q.size();
        endfunction

        function bit waiting_data();
            return awaiting;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;
    int   random_items = 0;
    int   cycle_count;

    job_scoreboard sb;

    dwm_cmd_if cmd_ch ();
    dwm_res_if res_ch ();

    decimal_word_machine_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One cmd transfer; valid stays high if the next item follows without a gap.
    task automatic send(mode_t m, logic [WORD_W-1:0] w, output status_t st);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= m;
        cmd_ch.word  <= w;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        st = sb.note_command(m, w);
        if (m <= MODE_DATA)
            random_items++;
    endtask

    function automatic logic [WORD_W-1:0] gen_instr();
        logic [7:0] d2;
        logic [7:0] d3;
        int         pick;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
            d2 = 8'($urandom);
            d3 = 8'($urandom);
        end
        else begin
            // bias towards the low blocks where the program sits
            d2 = 8'(CH_0 + ($urandom_range(1) ? $urandom_range(2) : $urandom_range(9)));
            d3 = 8'(CH_0 + $urandom_range(9));
        end
        if (pick < 15)
            return {CH_G, CH_D, d2, d3};
        else if (pick < 28)
            return {CH_P, CH_D, d2, d3};
        else if (pick < 32)
            return {CH_H, 24'($urandom)};
        else if (pick < 47)
            return {CH_L, CH_R, d2, d3};
        else if (pick < 60)
            return {CH_S, CH_R, d2, d3};
        else if (pick < 73)
            return {CH_C, CH_R, d2, d3};
        else if (pick < 86)
            return {CH_B, CH_T, d2, d3};
        else if (pick < 95)
            return {8'($urandom_range(1, 255)), 24'($urandom)};
        else
            return $urandom;
    endfunction

    task automatic feed_card();
        status_t          st;
        logic [WORD_W-1:0] w;
        while (sb.waiting_data()) begin
            if ($urandom_range(7) == 0)
                w = {8'h00, 24'($urandom)};
            else
                w = {8'($urandom_range(1, 255)), 24'($urandom)};
            send(MODE_DATA, w, st);
            if ($urandom_range(29) == 0)
                break;
        end
    endtask

    task automatic random_job();
        status_t st;
        int      n;
        int      steps;
        send(MODE_NEW, $urandom, st);
        n = $urandom_range(3, 14);
        repeat (n)
            send(MODE_LOAD, gen_instr(), st);
        send(MODE_START, $urandom, st);
        steps = $urandom_range(4, 24);
        for (int k = 0; k < steps; k++) begin
            if ($urandom_range(19) == 0)
                send(mode_t'($urandom_range(1, 7)), $urandom, st);
            send(MODE_STEP, $urandom, st);
            if ((st == ST_HALT || st == ST_END) && $urandom_range(3) != 0)
                break;
            if ($urandom_range(9) != 0)
                feed_card();
        end
    endtask

    // Fills the store to the end, then pushes past it.
    task automatic full_memory_job();
        status_t           st;
        logic [WORD_W-1:0] w;
        send(MODE_NEW, $urandom, st);
        for (int i = 0; i < MEM_WORDS; i++) begin
            if (i == 0 || i == MEM_WORDS - 1)
                w = '1;
            else if (i == MEM_WORDS / 2)
                w = '0;
            else if ($urandom_range(1))
                w = gen_instr();
            else
                w = {8'($urandom_range(1, 255)), 24'($urandom)};
            send(MODE_LOAD, w, st);
        end
        send(MODE_LOAD, $urandom, st);
        send(MODE_LOAD, '1, st);
        send(MODE_STEP, $urandom, st);
        send(MODE_START, $urandom, st);
        repeat (12) begin
            send(MODE_STEP, $urandom, st);
            feed_card();
        end
    endtask

    task automatic directed_part();
        status_t st;
        send(MODE_STEP, '0, st);              // empty store: program ended
        send(MODE_DATA, '1, st);              // data with no GD pending
        send(MODE_SPARE, '0, st);
        send(MODE_NEW, '1, st);
        send(MODE_LOAD, {CH_G, CH_D, "10"}, st);
        send(MODE_LOAD, {CH_P, CH_D, "10"}, st);
        send(MODE_LOAD, {CH_C, CH_R, "11"}, st);
        send(MODE_LOAD, {CH_B, CH_T, "05"}, st);
        send(MODE_LOAD, {CH_L, CH_R, "x1"}, st);
        send(MODE_LOAD, {CH_H, "000"}, st);
        send(MODE_START, '0, st);
        send(MODE_STEP, '0, st);              // GD
        send(MODE_STEP, '0, st);              // still waiting for the card
        send(MODE_DATA, "ABCD", st);
        send(MODE_DATA, 32'h00FF_FFFF, st);   // empty word ends the card
        send(MODE_STEP, '0, st);              // PD
        send(MODE_STEP, '0, st);              // CR, toggle set (zero equals R)
        send(MODE_STEP, '0, st);              // BT taken to the H word
        send(MODE_STEP, '0, st);              // H
        send(MODE_STEP, '0, st);              // H again
        send(MODE_STEP, '0, st);              // H again
    endtask

    // Result side: check every transfer and stall at random.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.status, res_ch.out_word, res_ch.block, res_ch.last);
            res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.owed());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int jobs;
        sb = new();
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.mode  <= MODE_NEW;
        cmd_ch.word  <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();

        random_items = 0;
        jobs = 0;
        while (random_items < RANDOM_GOAL) begin
            if (jobs == 1) begin
                calm <= 1'b1;
                full_memory_job();
                calm <= 1'b0;
            end
            else begin
                random_job();
            end
            jobs++;
        end
        cmd_ch.valid <= 1'b0;

        while (sb.owed() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        if (sb.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
